[rtl/fft_pkg.sv]
`timescale 1ns / 1ps
package fft_pkg;
  localparam int MAX_POINTS_DEF   = 64;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int TWIDDLE_BITS_DEF = 16;
  localparam int DATA_BITS = 23;
  localparam int MAX_LOG2  = 6;
  localparam int IDX_BITS  = 6;
  localparam int TW_FRAC   = 15;

  localparam logic [0:0] REG_SIZE = 1'b0;
  localparam logic [0:0] REG_INV  = 1'b1;

  typedef struct packed {
    logic load;
    logic swap_rd;
    logic swap_wr;
    logic bf_rd;
    logic bf_mul;
    logic bf_wr;
    logic scl_rd;
    logic scl_wr;
    logic out_rd;
    logic out_emit;
  } fft_cmd_t;

  function automatic logic [16:0] quarter_cos(input logic [4:0] k);
    logic [16:0] v;
    begin
      case (k)
        5'd0: v = 17'd32768;  5'd1: v = 17'd32610;  5'd2: v = 17'd32138;
        5'd3: v = 17'd31357;  5'd4: v = 17'd30274;  5'd5: v = 17'd28899;
        5'd6: v = 17'd27246;  5'd7: v = 17'd25330;  5'd8: v = 17'd23170;
        5'd9: v = 17'd20788;  5'd10: v = 17'd18205; 5'd11: v = 17'd15447;
        5'd12: v = 17'd12540; 5'd13: v = 17'd9512;  5'd14: v = 17'd6393;
        5'd15: v = 17'd3212;  default: v = 17'd0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [DATA_BITS-1:0] sat(input logic signed [39:0] x);
    logic signed [DATA_BITS-1:0] r;
    begin
      if (x > 40'sd4194303) r = 23'sd4194303;
      else if (x < -40'sd4194304) r = -23'sd4194304;
      else r = x[DATA_BITS-1:0];
      return r;
    end
  endfunction
endpackage

[rtl/fft_ctrl.sv]
`timescale 1ns / 1ps
module fft_ctrl import fft_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          size_log2,
  input  logic                inverse_mode,
  output fft_cmd_t            cmd,
  output logic [IDX_BITS-1:0] addr_a,
  output logic [IDX_BITS-1:0] addr_b,
  output logic [4:0]          tw_idx,
  output logic [2:0]          lg,
  output logic                last
);
  typedef enum logic [7:0] {
    S_LOAD = 8'b00000001, S_SWR = 8'b00000010, S_SWW = 8'b00000100,
    S_BRD  = 8'b00001000, S_BMU = 8'b00010000, S_BWR = 8'b00100000,
    S_SCL  = 8'b01000000, S_OUT = 8'b10000000
  } st_t;

  st_t state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;      // load count / general index
  logic [2:0] stg_r, stg_nxt;
  logic [2:0] lg_r, lg_nxt;
  logic       ph_r, ph_nxt;        // sub-phase: read, then write or emit
  logic [6:0] n_cur;
  logic [2:0] lg_act;
  logic [5:0] i6, rev, k_part, grp, lo_mask, half;
  logic [6:0] nl;

  always_comb begin
    lg_act = (size_log2 == 3'd0) ? 3'd1 : (size_log2 == 3'd7) ? 3'd6 : size_log2;
    n_cur = 7'd1 << lg_act;
    nl = 7'd1 << lg_r;
    i6 = cnt_r[5:0];
    rev = '0;
    for (int b = 0; b < MAX_LOG2; b++)
      if (b < lg_r) rev[lg_r - 3'd1 - 3'(b)] = i6[b];
    half = 6'd1 << (stg_r - 3'd1);
    lo_mask = half - 6'd1;
    k_part = i6 & lo_mask;
    grp = (i6 & ~lo_mask) << 1;
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; stg_nxt = stg_r; lg_nxt = lg_r; ph_nxt = ph_r;
    cmd = '0; busy = 1'b1; last = 1'b0;
    addr_a = i6; addr_b = i6; tw_idx = '0;
    unique case (state_r)
      S_LOAD: begin
        busy = 1'b0;
        addr_a = (cnt_r >= n_cur) ? 6'd0 : i6;
        if (start) begin
          cmd.load = 1'b1;
          if (((cnt_r >= n_cur) ? 7'd1 : cnt_r + 7'd1) == n_cur) begin
            cnt_nxt = '0; lg_nxt = lg_act; state_nxt = S_SWR;
          end else cnt_nxt = (cnt_r >= n_cur) ? 7'd1 : cnt_r + 7'd1;
        end
      end
      S_SWR: begin
        addr_a = i6; addr_b = rev;
        if (i6 < rev) begin cmd.swap_rd = 1'b1; state_nxt = S_SWW; end
        else if (cnt_r + 7'd1 == nl) begin
          cnt_nxt = '0; stg_nxt = 3'd1; state_nxt = S_BRD;
        end else cnt_nxt = cnt_r + 7'd1;
      end
      S_SWW: begin
        addr_a = i6; addr_b = rev; cmd.swap_wr = 1'b1;
        if (cnt_r + 7'd1 == nl) begin
          cnt_nxt = '0; stg_nxt = 3'd1; state_nxt = S_BRD;
        end else begin cnt_nxt = cnt_r + 7'd1; state_nxt = S_SWR; end
      end
      S_BRD: begin
        addr_a = grp | k_part; addr_b = grp | k_part | half;
        cmd.bf_rd = 1'b1; state_nxt = S_BMU;
      end
      S_BMU: begin
        addr_a = grp | k_part; addr_b = grp | k_part | half;
        tw_idx = 5'((k_part << (3'd6 - stg_r)) & 6'd31);
        cmd.bf_mul = 1'b1; state_nxt = S_BWR;
      end
      S_BWR: begin
        addr_a = grp | k_part; addr_b = grp | k_part | half;
        cmd.bf_wr = 1'b1; state_nxt = S_BRD;
        if (cnt_r + 7'd1 == (nl >> 1)) begin
          cnt_nxt = '0;
          if (stg_r == lg_r) state_nxt = inverse_mode ? S_SCL : S_OUT;
          else stg_nxt = stg_r + 3'd1;
        end else cnt_nxt = cnt_r + 7'd1;
      end
      S_SCL: begin
        addr_a = i6;
        if (!ph_r) begin cmd.scl_rd = 1'b1; ph_nxt = 1'b1; end
        else begin
          cmd.scl_wr = 1'b1; ph_nxt = 1'b0;
          if (cnt_r + 7'd1 == nl) begin cnt_nxt = '0; state_nxt = S_OUT; end
          else cnt_nxt = cnt_r + 7'd1;
        end
      end
      S_OUT: begin
        addr_a = i6;
        if (!ph_r) begin cmd.out_rd = 1'b1; ph_nxt = 1'b1; end
        else begin
          cmd.out_emit = 1'b1; ph_nxt = 1'b0;
          last = (cnt_r + 7'd1 == nl);
          if (last) begin cnt_nxt = '0; state_nxt = S_LOAD; end
          else cnt_nxt = cnt_r + 7'd1;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  assign lg = lg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; stg_r <= 3'd1; lg_r <= 3'd6; ph_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; stg_r <= stg_nxt;
      lg_r <= lg_nxt; ph_r <= ph_nxt;
    end
  end
endmodule

[rtl/fft_dp.sv]
`timescale 1ns / 1ps
module fft_dp import fft_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  fft_cmd_t                      cmd,
  input  logic [IDX_BITS-1:0]           addr_a,
  input  logic [IDX_BITS-1:0]           addr_b,
  input  logic [4:0]                    tw_idx,
  input  logic [2:0]                    lg,
  input  logic                          inverse_mode,
  input  logic                          last,
  input  logic signed [SAMPLE_BITS-1:0] in_re,
  input  logic signed [SAMPLE_BITS-1:0] in_im,
  output logic signed [DATA_BITS-1:0]   out_re,
  output logic signed [DATA_BITS-1:0]   out_im,
  output logic [IDX_BITS-1:0]           out_idx,
  output logic                          out_last,
  output logic                          out_vld
);
  logic [2*DATA_BITS-1:0] mem [2**IDX_BITS];
  logic signed [DATA_BITS-1:0] ar_r, ai_r, br_r, bi_r;
  logic signed [39:0] vr_r, vi_r;
  logic signed [16:0] wr, ws, wi;
  logic signed [39:0] pr, pi, sa, sb, ta, tb;
  logic signed [39:0] rnd, xr, xi;
  logic [IDX_BITS-1:0] widx_a;
  logic [2*DATA_BITS-1:0] wdat_a, wdat_b;
  logic we_a, we_b;

  always_comb begin
    if (tw_idx <= 5'd16) begin
      wr = quarter_cos(tw_idx); ws = quarter_cos(5'd16 - tw_idx);
    end else begin
      wr = -quarter_cos(5'd0 - tw_idx); ws = quarter_cos(tw_idx - 5'd16);
    end
    wi = inverse_mode ? ws : -ws;
    // Products are rounded by adding half an LSB and shifting arithmetically.
    pr = 40'(br_r) * 40'(wr) - 40'(bi_r) * 40'(wi);
    pi = 40'(br_r) * 40'(wi) + 40'(bi_r) * 40'(wr);
    sa = 40'(ar_r) + vr_r; sb = 40'(ai_r) + vi_r;
    ta = 40'(ar_r) - vr_r; tb = 40'(ai_r) - vi_r;
    rnd = (lg == 3'd0) ? 40'sd0 : (40'sd1 <<< (lg - 3'd1));
    xr = (40'(ar_r) + rnd) >>> lg;
    xi = (40'(ai_r) + rnd) >>> lg;
    we_a = 1'b0; we_b = 1'b0; widx_a = addr_a;
    wdat_a = '0; wdat_b = {br_r, bi_r};
    if (cmd.load) begin
      we_a = 1'b1;
      wdat_a = {sat(40'(in_re)), sat(40'(in_im))};
    end else if (cmd.swap_wr) begin
      we_a = 1'b1; we_b = 1'b1; wdat_a = {br_r, bi_r}; wdat_b = {ar_r, ai_r};
    end else if (cmd.bf_wr) begin
      we_a = 1'b1; we_b = 1'b1;
      wdat_a = {sat(sa), sat(sb)}; wdat_b = {sat(ta), sat(tb)};
    end else if (cmd.scl_wr) begin
      we_a = 1'b1; wdat_a = {sat(xr), sat(xi)};
    end
  end

  always_ff @(posedge clk) begin
    if (we_a) mem[widx_a] <= wdat_a;
    if (we_b) mem[addr_b] <= wdat_b;
    if (cmd.swap_rd || cmd.bf_rd || cmd.scl_rd || cmd.out_rd) begin
      {ar_r, ai_r} <= mem[addr_a];
      {br_r, bi_r} <= mem[addr_b];
    end
    if (cmd.bf_mul) begin
      vr_r <= (pr + 40'sd16384) >>> TW_FRAC;
      vi_r <= (pi + 40'sd16384) >>> TW_FRAC;
    end
    out_vld <= cmd.out_emit;
    out_re <= ar_r; out_im <= ai_r; out_idx <= addr_a; out_last <= last;
  end
endmodule

[rtl/radix2_complex_fft_core.sv]
`timescale 1ns / 1ps
// Radix-2 FFT/IFFT over 2..64 complex points. Samples load one per cycle
// while busy is low; the Nth sample starts the transform, during which busy
// stays high: N bit-reverse steps (plus a read and a write per swap), then
// N/2*log2N butterflies, each a read, multiply and write on one butterfly
// unit, a read and a write per bin for inverse scaling, then a read and an
// emit per bin of output. Each bin word appears for one cycle with out_valid;
// the receiver cannot stall, so it must take every word. The frame time is
// set mostly by the butterflies on the single frame memory.
module radix2_complex_fft_core import fft_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_re,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_im,
  output logic                          out_valid,
  output logic signed [DATA_BITS-1:0]   out_bin_re,
  output logic signed [DATA_BITS-1:0]   out_bin_im,
  output logic [IDX_BITS-1:0]           out_bin_index,
  output logic                          out_last_bin,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [0:0]                    cfg_index,
  input  logic [2:0]                    cfg_data
);
  logic [2:0] size_r;
  logic inv_r;
  fft_cmd_t cmd;
  logic [IDX_BITS-1:0] addr_a, addr_b;
  logic [4:0] tw_idx;
  logic [2:0] lg;
  logic last;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 3'd6; inv_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SIZE: size_r <= cfg_data;
        REG_INV:  inv_r <= cfg_data[0];
      endcase
    end
  end

  fft_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .size_log2(size_r), .inverse_mode(inv_r),
    .cmd, .addr_a, .addr_b, .tw_idx, .lg, .last
  );

  fft_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk, .cmd, .addr_a, .addr_b, .tw_idx, .lg, .inverse_mode(inv_r), .last,
    .in_re(in_sample_re), .in_im(in_sample_im),
    .out_re(out_bin_re), .out_im(out_bin_im), .out_idx(out_bin_index),
    .out_last(out_last_bin), .out_vld(out_valid)
  );
endmodule

[test/tb_radix2_complex_fft_core.sv]
`timescale 1ns / 1ps
module tb_radix2_complex_fft_core;
  import fft_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;

  typedef enum logic [1:0] {OP_SAMPLE, OP_CFG, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t kind;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [0:0] reg_idx;
    logic [2:0] reg_val;
    int gap;
  } fft_op_t;

  typedef struct {
    logic signed [DATA_BITS-1:0] re;
    logic signed [DATA_BITS-1:0] im;
    logic [IDX_BITS-1:0] index;
    logic last;
  } bin_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_sample_re = '0;
  logic signed [15:0] in_sample_im = '0;
  logic out_valid;
  logic signed [DATA_BITS-1:0] out_bin_re;
  logic signed [DATA_BITS-1:0] out_bin_im;
  logic [IDX_BITS-1:0] out_bin_index;
  logic out_last_bin;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [2:0] cfg_data = '0;

  radix2_complex_fft_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample_re(in_sample_re), .in_sample_im(in_sample_im),
    .out_valid(out_valid), .out_bin_re(out_bin_re), .out_bin_im(out_bin_im),
    .out_bin_index(out_bin_index), .out_last_bin(out_last_bin),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fft_op_t pending_ops[$];
  bin_word_t expected_bins[$];
  int fails = 0;
  int cycles = 0;
  int quiet_cycles = 0;
  int gap_left = 0;

  // Predictor state.
  longint frame_re[0:63];
  longint frame_im[0:63];
  int fill_count = 0;
  logic [2:0] cur_size_log2 = 3'd6;
  logic cur_inverse = 1'b0;
  longint cos_tab[0:16] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246,
                            25330, 23170, 20788, 18205, 15447, 12540, 9512,
                            6393, 3212, 0};

  function automatic longint clip23(longint x);
    if (x > 64'sd4194303) return 64'sd4194303;
    if (x < -64'sd4194304) return -64'sd4194304;
    return x;
  endfunction

  function automatic longint round_shift(longint x, int s);
    if (s == 0) return x;
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  task automatic run_transform(int lg);
    int n, r, len, half, stride, t;
    longint wr, ws, wi, vr, vi, ur, ui, qr, qi, tmp;
    n = 1 << lg;
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int b = 0; b < lg; b++) r |= ((i >> b) & 1) << (lg - 1 - b);
      if (i < r) begin
        tmp = frame_re[i]; frame_re[i] = frame_re[r]; frame_re[r] = tmp;
        tmp = frame_im[i]; frame_im[i] = frame_im[r]; frame_im[r] = tmp;
      end
    end
    for (int st = 1; st <= lg; st++) begin
      len = 1 << st;
      half = len >> 1;
      stride = 64 >> st;
      for (int i = 0; i < n; i += len) begin
        for (int k = 0; k < half; k++) begin
          t = (k * stride) & 31;
          if (t <= 16) begin
            wr = cos_tab[t];
            ws = cos_tab[16 - t];
          end else begin
            wr = -cos_tab[32 - t];
            ws = cos_tab[t - 16];
          end
          wi = cur_inverse ? ws : -ws;
          ur = frame_re[i + k];
          ui = frame_im[i + k];
          qr = frame_re[i + k + half];
          qi = frame_im[i + k + half];
          vr = round_shift(qr * wr - qi * wi, TW_FRAC);
          vi = round_shift(qr * wi + qi * wr, TW_FRAC);
          frame_re[i + k] = clip23(ur + vr);
          frame_im[i + k] = clip23(ui + vi);
          frame_re[i + k + half] = clip23(ur - vr);
          frame_im[i + k + half] = clip23(ui - vi);
        end
      end
    end
    if (cur_inverse) begin
      for (int i = 0; i < n; i++) begin
        frame_re[i] = clip23(round_shift(frame_re[i], lg));
        frame_im[i] = clip23(round_shift(frame_im[i], lg));
      end
    end
  endtask

  task automatic predict_sample(logic signed [15:0] re, logic signed [15:0] im);
    int lg, n;
    bin_word_t w;
    lg = (cur_size_log2 < 1) ? 1 : ((cur_size_log2 > MAX_LOG2) ? MAX_LOG2 : cur_size_log2);
    n = 1 << lg;
    if (fill_count >= n) fill_count = 0;
    frame_re[fill_count & 63] = re;
    frame_im[fill_count & 63] = im;
    fill_count++;
    if (fill_count < n) return;
    fill_count = 0;
    run_transform(lg);
    for (int i = 0; i < n; i++) begin
      w.re = frame_re[i][DATA_BITS-1:0];
      w.im = frame_im[i][DATA_BITS-1:0];
      w.index = i[IDX_BITS-1:0];
      w.last = (i == n - 1);
      expected_bins.push_back(w);
    end
  endtask

  task automatic report(string what, bin_word_t got, bin_word_t want);
    fails++;
    $display("MISMATCH %s: got re=%0d im=%0d idx=%0d last=%0b, want re=%0d im=%0d idx=%0d last=%0b",
             what, got.re, got.im, got.index, got.last, want.re, want.im, want.index,
             want.last);
  endtask

  // Driver.
  always @(posedge clk) begin
    logic nxt_start, nxt_cfg;
    fft_op_t op;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("== FAIL ==");
      $finish;
    end else if (rst_n) begin
      nxt_start = start;
      nxt_cfg = cfg_valid;
      quiet_cycles = (expected_bins.size() == 0 && !out_valid) ? quiet_cycles + 1 : 0;
      if (start && !busy) begin
        predict_sample(in_sample_re, in_sample_im);
        nxt_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SIZE) cur_size_log2 = cfg_data;
        else cur_inverse = cfg_data[0];
        nxt_cfg = 1'b0;
      end
      if (!nxt_start && !nxt_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops[0];
          case (op.kind)
            OP_SAMPLE: begin
              void'(pending_ops.pop_front());
              nxt_start = 1'b1;
              in_sample_re <= op.re;
              in_sample_im <= op.im;
              gap_left = op.gap;
            end
            OP_CFG: begin
              // Registers change only once the core has gone quiet and no
              // frame is being transformed.
              if (quiet_cycles >= SETTLE_CYCLES && expected_bins.size() == 0) begin
                void'(pending_ops.pop_front());
                nxt_cfg = 1'b1;
                cfg_index <= op.reg_idx;
                cfg_data <= op.reg_val;
              end
            end
            default: begin
              if (expected_bins.size() == 0) void'(pending_ops.pop_front());
            end
          endcase
        end
      end
      start <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    bin_word_t got, want;
    if (rst_n && out_valid) begin
      got.re = out_bin_re;
      got.im = out_bin_im;
      got.index = out_bin_index;
      got.last = out_last_bin;
      if (expected_bins.size() == 0) begin
        want = '{default: '0};
        report("unexpected word", got, want);
      end else begin
        want = expected_bins.pop_front();
        if (got.re !== want.re) report("bin_re", got, want);
        if (got.im !== want.im) report("bin_im", got, want);
        if (got.index !== want.index) report("bin_index", got, want);
        if (got.last !== want.last) report("last_bin", got, want);
      end
    end
  end

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_sample(int re, int im, bit burst);
    fft_op_t op;
    op.kind = OP_SAMPLE;
    op.re = re[15:0];
    op.im = im[15:0];
    op.reg_idx = '0;
    op.reg_val = '0;
    op.gap = pick_gap(burst);
    pending_ops.push_back(op);
  endtask

  task automatic add_cfg(logic [0:0] idx, logic [2:0] val);
    fft_op_t op;
    op = '{kind: OP_CFG, re: '0, im: '0, reg_idx: idx, reg_val: val, gap: 0};
    pending_ops.push_back(op);
  endtask

  task automatic add_drain();
    fft_op_t op;
    op = '{kind: OP_DRAIN, re: '0, im: '0, reg_idx: '0, reg_val: '0, gap: 0};
    pending_ops.push_back(op);
  endtask

  function automatic int rand_sample();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      2: return $urandom_range(0, 15) - 8;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  initial begin
    int sent, lg, n;
    bit burst;
    // Directed: two-point frames at the extremes forward, then a four-point frame inverse.
    add_cfg(REG_SIZE, 3'd1);
    add_sample(32767, -32768, 0);
    add_sample(-32768, 32767, 0);
    add_sample(32767, 32767, 0);
    add_sample(32767, 32767, 0);
    add_cfg(REG_INV, 3'd1);
    add_cfg(REG_SIZE, 3'd2);
    add_sample(-32768, -32768, 0);
    add_sample(32767, 0, 0);
    add_sample(0, -32768, 0);
    add_sample(-1, 1, 0);
    // A size of zero behaves as two points.
    add_cfg(REG_INV, 3'd0);
    add_cfg(REG_SIZE, 3'd0);
    add_sample(-32768, -32768, 0);
    add_sample(-32768, -32768, 0);
    // Shrinking the size mid-frame restarts the frame with the next sample.
    add_cfg(REG_SIZE, 3'd3);
    for (int i = 0; i < 5; i++) add_sample(rand_sample(), rand_sample(), 1);
    add_cfg(REG_SIZE, 3'd1);
    add_sample(1000, -2000, 0);
    add_sample(-3000, 4000, 0);
    add_drain();

    sent = 0;
    while (sent < 190) begin
      case ($urandom_range(0, 9))
        0: lg = 7;
        1: lg = 6;
        2: lg = 0;
        3: lg = 5;
        default: lg = $urandom_range(1, 4);
      endcase
      add_cfg(REG_SIZE, lg[2:0]);
      add_cfg(REG_INV, 3'($urandom_range(0, 1)));
      n = 1 << ((lg < 1) ? 1 : ((lg > 6) ? 6 : lg));
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) add_sample(rand_sample(), rand_sample(), burst);
      if ($urandom_range(0, 4) == 0) add_drain();
      sent += n;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_ops.size() == 0 && !start && !cfg_valid && expected_bins.size() == 0);
    repeat (50) @(posedge clk);
    if (fails == 0 && expected_bins.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
